/* sv/swm_pkg.sv */
package swm_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_WINDOW  = 16;
  localparam int DEF_SAMPLE_BITS = 16;

  // Window size register.
  localparam int CFG_BITS     = 5;
  localparam int MIN_WINDOW   = 3;
  localparam int RESET_WINDOW = 5;

  // Command codes.
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_INIT = 1'b1;

  // Per-cell control, driven by the top level for each cell of the chain.
  typedef struct packed {
    logic init;           // Load the seed value and the initial age.
    logic load;           // An add word was accepted in this cycle.
    logic active;         // The cell lies inside the active window.
    logic has_left;       // A left neighbor exists inside the window.
    logic has_right;      // A right neighbor exists inside the window.
    logic before_oldest;  // The oldest entry sits to the right of this cell.
    logic at_oldest;      // This cell holds the oldest entry.
  } cell_ctrl_t;

endpackage

/* sv/swm_if.sv */
interface swm_in_if #(
  parameter int SAMPLE_BITS = swm_pkg::DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic signed [SAMPLE_BITS-1:0] sample_value;

  modport source(output valid, command, sample_value, input ready);
  modport sink(input valid, command, sample_value, output ready);
endinterface

interface swm_out_if #(
  parameter int SAMPLE_BITS = swm_pkg::DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] median_value;

  modport source(output valid, median_value, input ready);
  modport sink(input valid, median_value, output ready);
endinterface

/* sv/swm_cell.sv */
module swm_cell #(
  parameter int SAMPLE_BITS = swm_pkg::DEF_SAMPLE_BITS,
  parameter int AGE_W       = 4
) (
  input  logic                          clk,
  input  swm_pkg::cell_ctrl_t           ctrl,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic        [AGE_W-1:0]       init_age,
  input  logic signed [SAMPLE_BITS-1:0] left_val,
  input  logic        [AGE_W-1:0]       left_age,
  input  logic                          left_gt,
  input  logic signed [SAMPLE_BITS-1:0] right_val,
  input  logic        [AGE_W-1:0]       right_age,
  input  logic                          right_gt,
  output logic signed [SAMPLE_BITS-1:0] val,
  output logic        [AGE_W-1:0]       age,
  output logic                          gt,
  output logic signed [SAMPLE_BITS-1:0] val_next
);

  logic [AGE_W-1:0] age_next;
  logic             take_left;
  logic             take_right;

  assign gt = (val > x);

  // The oldest entry leaves a hole. Larger entries left of the hole move
  // right, smaller entries right of it move left, and the new sample drops
  // into the gap that opens at its sorted place.
  assign take_left  = ctrl.has_left && left_gt;
  assign take_right = ctrl.has_right && !right_gt;

  always_comb begin
    val_next = val;
    age_next = age;
    if (ctrl.init) begin
      val_next = x;
      age_next = init_age;
    end else if (ctrl.load && ctrl.active) begin
      if (ctrl.before_oldest) begin
        if (gt) begin
          if (take_left) begin
            val_next = left_val;
            age_next = left_age + AGE_W'(1);
          end else begin
            val_next = x;
            age_next = '0;
          end
        end else begin
          age_next = age + AGE_W'(1);
        end
      end else if (ctrl.at_oldest) begin
        if (take_left) begin
          val_next = left_val;
          age_next = left_age + AGE_W'(1);
        end else if (take_right) begin
          val_next = right_val;
          age_next = right_age + AGE_W'(1);
        end else begin
          val_next = x;
          age_next = '0;
        end
      end else begin
        if (take_right) begin
          val_next = right_val;
          age_next = right_age + AGE_W'(1);
        end else if (gt) begin
          age_next = age + AGE_W'(1);
        end else begin
          val_next = x;
          age_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
    age <= age_next;
  end

endmodule

/* sv/swm_obuf.sv */
module swm_obuf #(
  parameter int SAMPLE_BITS = swm_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic signed [SAMPLE_BITS-1:0] push_data,
  output logic                          full,
  output logic                          valid,
  input  logic                          ready,
  output logic signed [SAMPLE_BITS-1:0] data
);

  // Two-entry buffer: a head register that drives the output and a skid
  // register behind it.
  logic [1:0]                    count;
  logic signed [SAMPLE_BITS-1:0] skid;
  logic                          pop;

  assign pop   = valid && ready;
  assign valid = (count != 2'd0);
  assign full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case (count)
        2'd0: begin
          if (push) begin
            data  <= push_data;
            count <= 2'd1;
          end
        end
        2'd1: begin
          if (push && pop) begin
            data <= push_data;
          end else if (push) begin
            skid  <= push_data;
            count <= 2'd2;
          end else if (pop) begin
            count <= 2'd0;
          end
        end
        default: begin
          if (pop) begin
            data  <= skid;
            count <= 2'd1;
          end
        end
      endcase
    end
  end

endmodule

/* sv/sliding_window_median.sv */
// Sliding-window median: one word in, one median word out, for every word.
// Latency: the median of a word is registered in the output buffer when the
// word is accepted. Throughput: one word per cycle while the output buffer is
// not full, set by the cell chain, which updates its whole sorted window at once.
// Reset (synchronous, active high) fills the window with zeros, sets the
// active size to 5 (or MAX_WINDOW if smaller) and the size register to 5, and empties the output buffer.
module sliding_window_median #(
  parameter int MAX_WINDOW  = swm_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = swm_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [swm_pkg::CFG_BITS-1:0]  cfg_wdata,
  swm_in_if.sink                        samples,
  swm_out_if.source                     medians
);

  // AGE_W indexes a cell; SIZE_W holds the window size itself.
  localparam int AGE_W  = $clog2(MAX_WINDOW);
  localparam int SIZE_W = $clog2(MAX_WINDOW + 1);
  localparam int RESET_SIZE = (swm_pkg::RESET_WINDOW > MAX_WINDOW) ?
                              MAX_WINDOW : swm_pkg::RESET_WINDOW;

  // The window size register only takes effect when an initialize word
  // latches it, clamped, into the active size.
  logic [swm_pkg::CFG_BITS-1:0] window_size;
  logic [SIZE_W-1:0]            active_size;
  logic [SIZE_W-1:0]            init_size;
  logic [31:0]                  req_size;
  logic [31:0]                  clamped_size;

  logic accept;
  logic accept_init;
  logic accept_add;
  logic buf_full;

  assign samples.ready = !buf_full;
  assign accept        = samples.valid && samples.ready;
  assign accept_init   = accept && (samples.command == swm_pkg::CMD_INIT);
  assign accept_add    = accept && (samples.command == swm_pkg::CMD_ADD);

  always_comb begin
    req_size = 32'(window_size);
    if (req_size < 32'(swm_pkg::MIN_WINDOW)) begin
      clamped_size = 32'(swm_pkg::MIN_WINDOW);
    end else if (req_size > 32'(MAX_WINDOW)) begin
      clamped_size = 32'(MAX_WINDOW);
    end else begin
      clamped_size = req_size;
    end
  end

  // Reset reuses the initialize path of the cells with a zero seed and the
  // reset size, so the chain itself needs no reset.
  assign init_size = rst ? SIZE_W'(RESET_SIZE) : SIZE_W'(clamped_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= swm_pkg::CFG_BITS'(swm_pkg::RESET_WINDOW);
      active_size <= SIZE_W'(RESET_SIZE);
    end else begin
      if (cfg_we) begin
        window_size <= cfg_wdata;
      end
      if (accept_init) begin
        active_size <= init_size;
      end
    end
  end

  // The chain holds the active window sorted in ascending order from cell 0.
  // Each entry carries its age, so the oldest one is found by the cell whose
  // age equals the window size minus one.
  logic signed [SAMPLE_BITS-1:0] seed;
  logic signed [SAMPLE_BITS-1:0] cell_val      [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] cell_val_next [MAX_WINDOW];
  logic        [AGE_W-1:0]       cell_age      [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]         cell_gt;
  logic [MAX_WINDOW-1:0]         is_oldest;
  logic [MAX_WINDOW-1:0]         oldest_right;
  logic [AGE_W-1:0]              oldest_age;

  assign seed       = rst ? '0 : samples.sample_value;
  assign oldest_age = AGE_W'(active_size - SIZE_W'(1));

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    localparam int LEFT  = (i == 0) ? 0 : i - 1;
    localparam int RIGHT = (i == MAX_WINDOW - 1) ? i : i + 1;

    swm_pkg::cell_ctrl_t ctrl;
    logic [AGE_W-1:0]    init_age;

    assign is_oldest[i] = (SIZE_W'(i) < active_size) && (cell_age[i] == oldest_age);

    // The "oldest lies to my right" flag ripples leftward from the last cell.
    if (i == MAX_WINDOW - 1) begin : g_last
      assign oldest_right[i] = 1'b0;
    end else begin : g_mid
      assign oldest_right[i] = is_oldest[RIGHT] || oldest_right[RIGHT];
    end

    assign ctrl.init          = rst || accept_init;
    assign ctrl.load          = accept_add;
    assign ctrl.active        = (SIZE_W'(i) < active_size);
    assign ctrl.has_left      = (i != 0);
    assign ctrl.has_right     = (SIZE_W'(i + 1) < active_size);
    assign ctrl.before_oldest = oldest_right[i];
    assign ctrl.at_oldest     = is_oldest[i];

    // After an initialize every slot holds the seed, so any distinct set of
    // ages gives the right arrival order; cell 0 is made the oldest.
    assign init_age = AGE_W'(init_size - SIZE_W'(1) - SIZE_W'(i));

    swm_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .AGE_W       (AGE_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .x         (seed),
      .init_age  (init_age),
      .left_val  (cell_val[LEFT]),
      .left_age  (cell_age[LEFT]),
      .left_gt   (cell_gt[LEFT]),
      .right_val (cell_val[RIGHT]),
      .right_age (cell_age[RIGHT]),
      .right_gt  (cell_gt[RIGHT]),
      .val       (cell_val[i]),
      .age       (cell_age[i]),
      .gt        (cell_gt[i]),
      .val_next  (cell_val_next[i])
    );
  end

  // The median is the middle cell of the updated window. An initialize word
  // loads the new size in the same edge, so its median is taken directly from
  // the seed, which every active cell then holds.
  logic [AGE_W-1:0]              median_idx;
  logic signed [SAMPLE_BITS-1:0] median_next;

  assign median_idx  = AGE_W'(active_size >> 1);
  assign median_next = accept_init ? seed : cell_val_next[median_idx];

  // The output buffer lets a new word in while a median waits to be taken.
  swm_obuf #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (median_next),
    .full      (buf_full),
    .valid     (medians.valid),
    .ready     (medians.ready),
    .data      (medians.median_value)
  );

endmodule

/* sv/swm_check.sv */
module swm_check #(
  parameter int SAMPLE_BITS = swm_pkg::DEF_SAMPLE_BITS
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_command,
  input logic signed [SAMPLE_BITS-1:0] in_sample,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] out_median
);

  // No median comes out of reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("median word valid right after reset");

  // An initialize word into an empty output returns its seed next cycle.
  a_init_seed: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_command == swm_pkg::CMD_INIT) && !out_valid)
    |=> (out_valid && (out_median == $past(in_sample))))
    else $error("initialize word did not return its seed");

  // Input backpressure only appears while medians are pending.
  a_ready_pending: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending median");

  // A stalled median word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_median)))
    else $error("stalled median word changed");

endmodule

bind sliding_window_median swm_check #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_swm_check (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (samples.valid),
  .in_ready   (samples.ready),
  .in_command (samples.command),
  .in_sample  (samples.sample_value),
  .out_valid  (medians.valid),
  .out_ready  (medians.ready),
  .out_median (medians.median_value)
);
